@@ rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// shared widths, codes and defaults for the lcs length engine
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int MAX_LEN_DEF = 64;

	localparam int FUNC_W      = 2;
	localparam int SYM_W       = 8;
	localparam int LEN_FIELD_W = 7;
	localparam int OUT_DATA_W  = 8;

	localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_MAX = 7'd127;

	// func codes
	localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FINISH   = 2'd2;

endpackage

@@ rtl/lcs_length_engine_top.sv @@
// ----------------------------------------------------------------------------
// lcs_length_engine_top
// longest common subsequence length of two loaded byte strings, computed
// row by row with one shared compare/max unit over a single row memory
// ----------------------------------------------------------------------------
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: symbol, tuser: func
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: lcs_length, tuser: overflow
//
// an append item is written into its string memory in the cycle it is accepted
// a finish item walks the table of strings of m and n bytes row by row: a
// fetch of the a byte in ST_ROW, then per cell a read (ST_CELL_RD) and a write
// (ST_CELL_WR) on the row memory; it goes straight to done if either is empty
// reset clears lengths, overflow flag, sequencer and output valid; the string
// and row memories need no clearing
// appends are accepted while a result waits; a finish waits in done until the
// output register is free
// ----------------------------------------------------------------------------
module lcs_length_engine_top #(
	parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lcs_pkg::SYM_W-1:0]       s_axis_tdata,  // [7:0] symbol
	input  logic [lcs_pkg::FUNC_W-1:0]      s_axis_tuser,  // [1:0] func
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lcs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [6:0] lcs_length, [7] zero
	output logic                            m_axis_tuser   // [0] overflow
);
	import lcs_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int EXT_W = (LEN_W > LEN_FIELD_W) ? LEN_W : LEN_FIELD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_CELL_RD,
		ST_CELL_WR,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [SYM_W-1:0] mem_a [MAX_LEN];
	logic [SYM_W-1:0] mem_b [MAX_LEN];
	logic [LEN_W-1:0] mem_dp [MAX_LEN];

	logic [LEN_W-1:0] len_a_q, len_b_q;
	logic             ovf_q;
	logic [LEN_W-1:0] i_q, j_q;
	logic [LEN_W-1:0] diag_q, left_q, res_q;
	logic [SYM_W-1:0] a_sym_q, b_sym_q;
	logic [LEN_W-1:0] dp_rd_q;
	logic             m_valid_q;
	logic [LEN_FIELD_W-1:0] m_len_q;
	logic             m_ovf_q;

	logic             in_acc;
	logic             wr_a, wr_b;
	logic             rd_a, rd_cell;
	logic             wr_dp;
	logic [LEN_W-1:0] up, cell_val, i_nxt, j_nxt;
	logic [EXT_W-1:0] res_ext;
	logic [LEN_FIELD_W-1:0] res_sat;
	logic             out_free;
	logic             out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign wr_a    = in_acc && (s_axis_tuser == FUNC_APPEND_A) && (len_a_q < LEN_W'(MAX_LEN));
	assign wr_b    = in_acc && (s_axis_tuser == FUNC_APPEND_B) && (len_b_q < LEN_W'(MAX_LEN));
	assign rd_a    = (state_q == ST_ROW);
	assign rd_cell = (state_q == ST_CELL_RD);
	assign wr_dp   = (state_q == ST_CELL_WR);

	// cell recurrence; first row sees zeros above
	assign up       = (i_q == '0) ? '0 : dp_rd_q;
	assign cell_val = (a_sym_q == b_sym_q) ? (diag_q + LEN_W'(1)) :
	                  ((up > left_q) ? up : left_q);
	assign i_nxt    = i_q + LEN_W'(1);
	assign j_nxt    = j_q + LEN_W'(1);

	assign res_ext  = EXT_W'(res_q);
	assign res_sat  = (res_ext > EXT_W'(LEN_FIELD_MAX)) ? LEN_FIELD_MAX :
	                  res_ext[LEN_FIELD_W-1:0];
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_DONE) && out_free;

	// string and row memories
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[len_a_q[IDX_W-1:0]] <= s_axis_tdata;
		end
		if (rd_a) begin
			a_sym_q <= mem_a[i_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[len_b_q[IDX_W-1:0]] <= s_axis_tdata;
		end
		if (rd_cell) begin
			b_sym_q <= mem_b[j_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_dp) begin
			mem_dp[j_q[IDX_W-1:0]] <= cell_val;
		end
		if (rd_cell) begin
			dp_rd_q <= mem_dp[j_q[IDX_W-1:0]];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_axis_tuser == FUNC_FINISH)) begin
					res_q <= '0;
				end
			end
			ST_ROW: begin
				diag_q <= '0;
				left_q <= '0;
			end
			ST_CELL_WR: begin
				diag_q <= up;
				left_q <= cell_val;
				res_q  <= cell_val;
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_a_q   <= '0;
			len_b_q   <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			m_valid_q <= 1'b0;
			m_len_q   <= '0;
			m_ovf_q   <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (s_axis_tuser)
							FUNC_APPEND_A: begin
								if (wr_a) begin
									len_a_q <= len_a_q + LEN_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							FUNC_APPEND_B: begin
								if (wr_b) begin
									len_b_q <= len_b_q + LEN_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							FUNC_FINISH: begin
								i_q <= '0;
								if ((len_a_q == '0) || (len_b_q == '0)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_ROW;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ROW: begin
					j_q     <= '0;
					state_q <= ST_CELL_RD;
				end
				ST_CELL_RD: begin
					state_q <= ST_CELL_WR;
				end
				ST_CELL_WR: begin
					if (j_nxt == len_b_q) begin
						if (i_nxt == len_a_q) begin
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_nxt;
							state_q <= ST_ROW;
						end
					end else begin
						j_q     <= j_nxt;
						state_q <= ST_CELL_RD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_len_q   <= res_sat;
						m_ovf_q   <= ovf_q;
						len_a_q   <= '0;
						len_b_q   <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(m_len_q);
	assign m_axis_tuser  = m_ovf_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_a_q <= LEN_W'(MAX_LEN)) && (len_b_q <= LEN_W'(MAX_LEN)))
		else $error("string length beyond capacity");

	a_cell_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL_WR) |-> (i_q < len_a_q) && (j_q < len_b_q))
		else $error("table cell outside loaded strings");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");

	a_busy_during_compute: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL_WR) && (j_nxt != len_b_q) |=> !s_axis_tready)
		else $error("input taken during table compute");

endmodule

@@ tb/sv/lcs_length_engine_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcs_length_engine_top_test
// streams tagged bytes for string a and string b into the engine, closes each
// job with a finish item and checks every length and overflow result against
// a dynamic-programming predictor kept inside the bench; small jobs dominate,
// a few jobs fill both strings to or past capacity, and both sides idle in phases
// ----------------------------------------------------------------------------
module lcs_length_engine_top_test;

	import lcs_pkg::*;

	localparam int MAX_LEN = MAX_LEN_DEF;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 160;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SYM_W-1:0]  symbol;
	} lcs_item_t;

	typedef struct packed {
		logic [LEN_FIELD_W-1:0] lcs_length;
		logic                   overflow;
	} lcs_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SYM_W-1:0]      s_axis_tdata = '0;
	logic [FUNC_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	lcs_item_t   item_pending [$];
	lcs_result_t lcs_expected [$];

	// predictor state
	logic [SYM_W-1:0] str_a [0:MAX_LEN-1];
	logic [SYM_W-1:0] str_b [0:MAX_LEN-1];
	int               len_a = 0;
	int               len_b = 0;
	bit               overflow_seen = 1'b0;

	int        items_total = 0;
	int        items_accepted = 0;
	int        error_count = 0;
	int        idle_phase = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	lcs_item_t next_item;

	lcs_length_engine_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [LEN_FIELD_W-1:0] lcs_of_loaded();
		int row [0:MAX_LEN];
		int diag;
		int up;
		int val;
		for (int j = 0; j <= MAX_LEN; j++)
			row[j] = 0;
		for (int i = 1; i <= len_a; i++) begin
			diag = 0;
			for (int j = 1; j <= len_b; j++) begin
				up = row[j];
				if (str_a[i-1] == str_b[j-1])
					val = diag + 1;
				else
					val = (up > row[j-1]) ? up : row[j-1];
				diag = up;
				row[j] = val;
			end
		end
		val = row[len_b];
		if (val > LEN_FIELD_MAX)
			return LEN_FIELD_MAX;
		return LEN_FIELD_W'(val);
	endfunction

	task automatic absorb_item(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
		lcs_result_t r;
		case (f)
		FUNC_APPEND_A: begin
			if (len_a < MAX_LEN) begin
				str_a[len_a] = s;
				len_a++;
			end else begin
				overflow_seen = 1'b1;
			end
		end
		FUNC_APPEND_B: begin
			if (len_b < MAX_LEN) begin
				str_b[len_b] = s;
				len_b++;
			end else begin
				overflow_seen = 1'b1;
			end
		end
		FUNC_FINISH: begin
			r.lcs_length = lcs_of_loaded();
			r.overflow = overflow_seen;
			lcs_expected.push_back(r);
			len_a = 0;
			len_b = 0;
			overflow_seen = 1'b0;
		end
		default: begin
		end
		endcase
	endtask

	task automatic check_result();
		lcs_result_t want;
		if (lcs_expected.size() == 0) begin
			$error("result with nothing expected: lcs_length %0d overflow %0d",
				m_axis_tdata[LEN_FIELD_W-1:0], m_axis_tuser);
			error_count++;
		end else begin
			want = lcs_expected.pop_front();
			if (m_axis_tdata[LEN_FIELD_W-1:0] !== want.lcs_length) begin
				$error("lcs_length: expected %0d, actual %0d", want.lcs_length,
					m_axis_tdata[LEN_FIELD_W-1:0]);
				error_count++;
			end
			if (m_axis_tuser !== want.overflow) begin
				$error("overflow: expected %0d, actual %0d", want.overflow, m_axis_tuser);
				error_count++;
			end
			if (m_axis_tdata[OUT_DATA_W-1:LEN_FIELD_W] !== '0) begin
				$error("tdata pad: expected 0, actual %0d",
					m_axis_tdata[OUT_DATA_W-1:LEN_FIELD_W]);
				error_count++;
			end
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_item(s_axis_tuser, s_axis_tdata);
				items_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (item_pending.size() > 0 &&
					!chance(idle_phase == 1 ? 71 : idle_phase == 3 ? 17 : 0)) begin
					next_item = item_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= next_item.func;
					s_axis_tdata <= next_item.symbol;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			idle_phase <= (items_accepted / PHASE_ITEMS) % 4;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			m_axis_tready <= (hold_left == 0) &&
				!chance(idle_phase == 2 ? 71 : idle_phase == 3 ? 17 : 0);
		end
	end

	// one long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_accepted >= 330) begin
			hold_left <= 3000;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic add_item(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
		lcs_item_t it;
		it.func = f;
		it.symbol = s;
		item_pending.push_back(it);
		items_total++;
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol(input int mode, input logic [SYM_W-1:0] base);
		case (mode)
		0: return SYM_W'($urandom);
		1: return base + SYM_W'($urandom_range(0, 3));
		default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	// loads both strings in random interleave, then closes the job
	task automatic load_job(input int la, input int lb, input bit copy_b);
		logic [SYM_W-1:0] sa [0:79];
		logic [SYM_W-1:0] sb [0:79];
		logic [SYM_W-1:0] base;
		int               mode;
		int               ia;
		int               ib;
		mode = $urandom_range(0, 2);
		base = SYM_W'($urandom);
		for (int k = 0; k < la; k++)
			sa[k] = pick_symbol(mode, base);
		for (int k = 0; k < lb; k++)
			sb[k] = (copy_b && k < la) ? sa[k] : pick_symbol(mode, base);
		ia = 0;
		ib = 0;
		while (ia < la || ib < lb) begin
			if (chance(4))
				add_item(FUNC_UNUSED, SYM_W'($urandom));
			if (ib >= lb || (ia < la && $urandom_range(0, 1))) begin
				add_item(FUNC_APPEND_A, sa[ia]);
				ia++;
			end else begin
				add_item(FUNC_APPEND_B, sb[ib]);
				ib++;
			end
		end
		add_item(FUNC_FINISH, SYM_W'($urandom));
	endtask

	initial begin
		int finishes;
		int long_jobs;
		int job_no;
		int waited;
		int n;
		logic [FUNC_W-1:0] f;

		// both strings empty
		add_item(FUNC_FINISH, 8'h00);
		// one string empty, the other holding extreme bytes
		add_item(FUNC_APPEND_A, 8'h00);
		add_item(FUNC_FINISH, 8'hFF);
		add_item(FUNC_APPEND_B, 8'hFF);
		add_item(FUNC_FINISH, 8'h00);
		// zero bytes as ordinary symbols, unused func code in between
		add_item(FUNC_APPEND_A, 8'h00);
		add_item(FUNC_APPEND_B, 8'hFF);
		add_item(FUNC_UNUSED, 8'hA5);
		add_item(FUNC_APPEND_A, 8'hFF);
		add_item(FUNC_APPEND_B, 8'h00);
		add_item(FUNC_APPEND_B, 8'hFF);
		add_item(FUNC_FINISH, 8'h5A);
		// crossed order gives one match
		add_item(FUNC_APPEND_A, 8'hAA);
		add_item(FUNC_APPEND_A, 8'h55);
		add_item(FUNC_APPEND_B, 8'h55);
		add_item(FUNC_APPEND_B, 8'hAA);
		add_item(FUNC_FINISH, 8'h00);
		// unused code alone
		add_item(FUNC_UNUSED, 8'hFF);
		add_item(FUNC_FINISH, 8'h00);
		finishes = 6;

		long_jobs = 0;
		job_no = 0;
		while (items_total < 1200 || finishes < 40) begin
			if (job_no == 0 || (long_jobs < 5 && chance(3))) begin
				// both strings filled, bytes past capacity dropped
				load_job(MAX_LEN + $urandom_range(0, 2), MAX_LEN + $urandom_range(0, 2),
					job_no == 0 || chance(50));
				long_jobs++;
				finishes++;
			end else if (chance(10)) begin
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++) begin
					f = FUNC_W'($urandom_range(0, 3));
					add_item(f, SYM_W'($urandom));
					if (f == FUNC_FINISH)
						finishes++;
				end
			end else begin
				load_job($urandom_range(0, 10), $urandom_range(0, 10), chance(20));
				finishes++;
			end
			job_no++;
		end
		add_item(FUNC_FINISH, SYM_W'($urandom));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_accepted < items_total)
			@(posedge clk);
		waited = 0;
		while (lcs_expected.size() > 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (lcs_expected.size() > 0) begin
			$error("%0d results never arrived", lcs_expected.size());
			error_count++;
		end
		if (error_count == 0)
			$display("lcs_length_engine_top_test: done, clean");
		else
			$display("lcs_length_engine_top_test: done, errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("lcs_length_engine_top_test: done, errors");
		$finish;
	end

endmodule

@@ lcs_length_engine_top.f @@
rtl/lcs_pkg.sv
rtl/lcs_length_engine_top.sv
tb/sv/lcs_length_engine_top_test.sv
